@@ src/utd_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-32 stream decoder.
// No dependencies; imported by every module of the decoder.
package utd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int IDX_W  = 16;
    localparam int PEND_W = 2;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // Lead byte range boundaries.
    localparam logic [BYTE_W-1:0] LEAD_MULTI  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_TWO    = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_THREE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_FOUR   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_BAD    = 8'hF5;

    // Payload masks for single bytes, leads and continuation bytes.
    localparam logic [BYTE_W-1:0] MASK_SINGLE = 8'h7F;
    localparam logic [BYTE_W-1:0] MASK_TWO    = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_THREE  = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_FOUR   = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_CONT   = 8'h3F;

    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [CP_W-1:0]   partial_value;
        logic [IDX_W-1:0]  out_count;
        logic              halted;
    } dec_state_t;

    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code_point;
        logic [IDX_W-1:0] char_index;
        kind_t            kind;
    } dec_result_t;

endpackage

@@ src/utd_decode.sv @@
// Single-pass decode of one byte: next decoder state and optional result.
// Depends on utd_pkg.
module utd_decode
    import utd_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  dec_state_t        cur,
    output dec_state_t        nxt,
    output dec_result_t       res
);

    logic [CP_W-1:0]  shifted;
    logic [IDX_W-1:0] count_inc;

    assign shifted   = {cur.partial_value[CP_W-7:0], in_byte[5:0] & MASK_CONT[5:0]};
    assign count_inc = (cur.out_count == IDX_MAX) ? cur.out_count
                                                  : cur.out_count + IDX_W'(1);

    always_comb
    begin
        nxt            = cur;
        res.valid      = 1'b0;
        res.code_point = '0;
        res.char_index = cur.out_count;
        res.kind       = KIND_CHAR;

        if (cur.halted)
        begin
            // Bytes are dropped until the next zero, which restarts silently.
            if (in_byte == '0)
            begin
                nxt = '0;
            end
        end
        else if (in_byte == '0)
        begin
            res.valid         = 1'b1;
            res.kind          = KIND_END;
            nxt.bytes_pending = PEND_NONE;
            nxt.partial_value = '0;
            nxt.out_count     = '0;
        end
        else if (cur.bytes_pending != PEND_NONE)
        begin
            nxt.partial_value = shifted;
            nxt.bytes_pending = cur.bytes_pending - PEND_ONE;
            if (cur.bytes_pending == PEND_ONE)
            begin
                res.valid      = 1'b1;
                res.code_point = shifted;
                nxt.out_count  = count_inc;
            end
        end
        else if (in_byte < LEAD_MULTI)
        begin
            res.valid      = 1'b1;
            res.code_point = CP_W'(in_byte & MASK_SINGLE);
            nxt.out_count  = count_inc;
        end
        else if (in_byte >= LEAD_TWO && in_byte < LEAD_THREE)
        begin
            nxt.partial_value = CP_W'(in_byte & MASK_TWO);
            nxt.bytes_pending = PEND_ONE;
        end
        else if (in_byte >= LEAD_THREE && in_byte < LEAD_FOUR)
        begin
            nxt.partial_value = CP_W'(in_byte & MASK_THREE);
            nxt.bytes_pending = PEND_TWO;
        end
        else if (in_byte >= LEAD_FOUR && in_byte < LEAD_BAD)
        begin
            nxt.partial_value = CP_W'(in_byte & MASK_FOUR);
            nxt.bytes_pending = PEND_THREE;
        end
        else
        begin
            // Overlong or out-of-range lead byte.
            res.valid         = 1'b1;
            res.kind          = KIND_ERR;
            nxt.halted        = 1'b1;
            nxt.bytes_pending = PEND_NONE;
            nxt.partial_value = '0;
        end
    end

endmodule

@@ src/utd_out_reg.sv @@
// Output result register with valid/ready handshake toward the consumer.
// Depends on utd_pkg.
module utd_out_reg
    import utd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dec_result_t      res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CP_W-1:0]  code_point,
    output logic [IDX_W-1:0] char_index,
    output logic [1:0]       kind
);

    logic             valid_reg;
    logic             valid_next;
    logic [CP_W-1:0]  cp_reg;
    logic [IDX_W-1:0] idx_reg;
    kind_t            kind_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= res.code_point;
            idx_reg  <= res.char_index;
            kind_reg <= res.kind;
        end
    end

    assign out_valid  = valid_reg;
    assign code_point = cp_reg;
    assign char_index = idx_reg;
    assign kind       = kind_reg;

endmodule

@@ src/utf8_to_utf32_stream_decoder_core.sv @@
// UTF-8 to UTF-32 stream decoder, top level. Depends on utd_pkg, utd_decode, utd_out_reg.
// Each accepted byte is held in the input register, decoded, and its result loaded into the output register.
// Throughput: one byte per cycle while the output register has room, set by the single-pass decode.
// Bytes that produce no result move on even while the output register is stalled.
// Reset clears both register valids and all decoder state (pending count, partial value,
// character index and halted flag); payload registers are not reset.
module utf8_to_utf32_stream_decoder_core
    import utd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CP_W-1:0]   code_point,
    output logic [IDX_W-1:0]  char_index,
    output logic [1:0]        kind
);

    // Input register: holds one accepted byte request until it is decoded.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    // Decoder state, updated once for every byte that leaves the input register.
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res;

    logic out_free;
    logic advance;

    utd_decode u_decode (
        .in_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res)
    );

    // A byte leaves the input register when its result, if any, has room in
    // the output register. Bytes without a result never wait.
    assign advance       = in_valid_reg && (!res.valid || out_free);
    assign in_ready      = !in_valid_reg || advance;
    assign in_valid_next = (in_valid && in_ready) || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    utd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res.valid),
        .res        (res),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .char_index (char_index),
        .kind       (kind)
    );

    // An error terminator always leaves the decoder halted.
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid && res.kind == KIND_ERR) |=> state_reg.halted)
        else $error("decoder not halted after an invalid lead byte");

    // While halted no sequence can be in progress.
    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted |-> (state_reg.bytes_pending == PEND_NONE
                              && state_reg.partial_value == '0))
        else $error("halted decoder holds a partial sequence");

    // A halted decoder emits nothing.
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted |-> !res.valid)
        else $error("halted decoder produced a result");

    // A zero byte always restarts the character index.
    a_zero_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_byte_reg == '0) |=> (state_reg.out_count == '0
                                             && !state_reg.halted))
        else $error("index not cleared after a zero byte");

endmodule
